// ===== rtl/psd_pkg.sv =====
// Shared types and constants of the point to segment distance unit.
package psd_pkg;

	// Width of the squared distance result.
	localparam int DIST_BITS = 34;

	// Depth of the queue between the classifying front end and the arithmetic back end.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	// How the projection parameter of an item is obtained.
	typedef enum logic [1:0] {
		T_ZERO,
		T_ONE,
		T_DIV
	} t_kind_t;

	// Control that travels with an item from the front end to the back end.
	typedef struct packed {
		t_kind_t kind;
		logic    degen;
	} item_ctrl_t;

endpackage

// ===== rtl/psd_front.sv =====
// Front end: segment and offset vectors, dot products and classification of t.
module psd_front
	import psd_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_BITS-1:0]  seg_start_x,
	input  logic signed [COORD_BITS-1:0]  seg_start_y,
	input  logic signed [COORD_BITS-1:0]  seg_start_z,
	input  logic signed [COORD_BITS-1:0]  seg_end_x,
	input  logic signed [COORD_BITS-1:0]  seg_end_y,
	input  logic signed [COORD_BITS-1:0]  seg_end_z,
	input  logic signed [COORD_BITS-1:0]  query_x,
	input  logic signed [COORD_BITS-1:0]  query_y,
	input  logic signed [COORD_BITS-1:0]  query_z,
	output logic                          q_valid,
	input  logic                          q_ready,
	output logic [3*(COORD_BITS+1)-1:0]   q_v,
	output logic [3*(COORD_BITS+1)-1:0]   q_d,
	output logic [2*(COORD_BITS+1)-1:0]   q_num,
	output logic [2*(COORD_BITS+1)-1:0]   q_den,
	output item_ctrl_t                    q_ctrl
);

	localparam int VW = COORD_BITS + 1;
	localparam int PW = 2 * VW;
	localparam int BW = PW + 2;
	localparam int AW = PW;

	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4;

	logic signed [COORD_BITS-1:0] p0 [3];
	logic signed [COORD_BITS-1:0] p1 [3];
	logic signed [COORD_BITS-1:0] qp [3];

	logic signed [VW-1:0] v_s1 [3];
	logic signed [VW-1:0] d_s1 [3];
	logic signed [VW-1:0] v_s2 [3];
	logic signed [VW-1:0] d_s2 [3];
	logic signed [PW-1:0] vv_s2 [3];
	logic signed [PW-1:0] vd_s2 [3];
	logic signed [VW-1:0] v_s3 [3];
	logic signed [VW-1:0] d_s3 [3];
	logic signed [BW-1:0] a_s3;
	logic signed [BW-1:0] b_s3;
	logic signed [VW-1:0] v_s4 [3];
	logic signed [VW-1:0] d_s4 [3];
	logic [AW-1:0]        num_s4;
	logic [AW-1:0]        den_s4;
	item_ctrl_t           ctrl_s4;

	logic signed [BW-1:0] num;
	item_ctrl_t           ctrl;

	assign en       = !vld_s4 || q_ready;
	assign in_ready = en;

	assign p0[0] = seg_start_x;
	assign p0[1] = seg_start_y;
	assign p0[2] = seg_start_z;
	assign p1[0] = seg_end_x;
	assign p1[1] = seg_end_y;
	assign p1[2] = seg_end_z;
	assign qp[0] = query_x;
	assign qp[1] = query_y;
	assign qp[2] = query_z;

	// The projection numerator is minus the dot product of v and d.
	always_comb begin
		num        = -b_s3;
		ctrl.degen = (a_s3 == '0);
		if (ctrl.degen || num <= 0) begin
			ctrl.kind = T_ZERO;
		end else if (num >= a_s3) begin
			ctrl.kind = T_ONE;
		end else begin
			ctrl.kind = T_DIV;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				v_s1[i]  <= VW'(p1[i]) - VW'(p0[i]);
				d_s1[i]  <= VW'(p0[i]) - VW'(qp[i]);
				v_s2[i]  <= v_s1[i];
				d_s2[i]  <= d_s1[i];
				vv_s2[i] <= v_s1[i] * v_s1[i];
				vd_s2[i] <= v_s1[i] * d_s1[i];
				v_s3[i]  <= v_s2[i];
				d_s3[i]  <= d_s2[i];
				v_s4[i]  <= v_s3[i];
				d_s4[i]  <= d_s3[i];
			end
			a_s3    <= BW'(vv_s2[0]) + BW'(vv_s2[1]) + BW'(vv_s2[2]);
			b_s3    <= BW'(vd_s2[0]) + BW'(vd_s2[1]) + BW'(vd_s2[2]);
			num_s4  <= num[AW-1:0];
			den_s4  <= a_s3[AW-1:0];
			ctrl_s4 <= ctrl;
		end
	end

	assign q_valid = vld_s4;
	assign q_v     = {v_s4[2], v_s4[1], v_s4[0]};
	assign q_d     = {d_s4[2], d_s4[1], d_s4[0]};
	assign q_num   = num_s4;
	assign q_den   = den_s4;
	assign q_ctrl  = ctrl_s4;

endmodule

// ===== rtl/psd_queue.sv =====
// Small first-in first-out queue between the front end and the back end.
module psd_queue
	import psd_pkg::*;
#(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0]       mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_q;
	logic [QUEUE_PTR_W-1:0] rd_q;
	logic [QUEUE_PTR_W:0]   cnt_q;
	logic                   push;
	logic                   pop;

	assign push_ready = (cnt_q != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/psd_back.sv =====
// Back end: pipelined restoring divider for t, then offsets, squares and their sum.
module psd_back
	import psd_pkg::*;
#(
	parameter int COORD_BITS  = 16,
	parameter int T_FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	output logic                        q_ready,
	input  logic [3*(COORD_BITS+1)-1:0] q_v,
	input  logic [3*(COORD_BITS+1)-1:0] q_d,
	input  logic [2*(COORD_BITS+1)-1:0] q_num,
	input  logic [2*(COORD_BITS+1)-1:0] q_den,
	input  item_ctrl_t                  q_ctrl,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [DIST_BITS-1:0]        dist_squared,
	output logic                        degenerate
);

	localparam int VW   = COORD_BITS + 1;
	localparam int AW   = 2 * VW;
	localparam int RW   = AW + 1;
	localparam int TF   = T_FRAC_BITS;
	localparam int TW   = TF + 1;
	localparam int PRW  = TW + 1 + VW;
	localparam int WW   = COORD_BITS + TF + 2;
	localparam int MW   = WW - 1;
	localparam int LW   = MW / 2;
	localparam int HW   = MW - LW;
	localparam int SQW  = 2 * MW;
	localparam int SUMW = SQW + 2;
	localparam int EXTW = (SUMW > 2 * TF + DIST_BITS) ? SUMW : 2 * TF + DIST_BITS;

	logic en;

	// Divider stages; index 0 is the queue head.
	logic              vld_s  [TF+1];
	logic [RW-1:0]     rem_s  [TF+1];
	logic [TF-1:0]     quo_s  [TF+1];
	logic [AW-1:0]     den_s  [TF+1];
	item_ctrl_t        ctl_s  [TF+1];
	logic [3*VW-1:0]   v_s    [TF+1];
	logic [3*VW-1:0]   d_s    [TF+1];

	logic                  vld_m1, vld_m2, vld_m3, vld_m4;
	logic signed [PRW-1:0] tv_m1 [3];
	logic signed [VW-1:0]  d_m1  [3];
	logic                  degen_m1, degen_m2, degen_m3, degen_m4;
	logic [MW-1:0]         mag_m2 [3];
	logic [2*HW-1:0]       hh_m3 [3];
	logic [HW+LW-1:0]      hl_m3 [3];
	logic [2*LW-1:0]       ll_m3 [3];
	logic [SQW-1:0]        sq_m4 [3];
	logic                  vld_o_q;
	logic [DIST_BITS-1:0]  dist_q;
	logic                  degen_q;

	logic [TW-1:0]         t;
	logic signed [WW-1:0]  w [3];
	logic [SUMW-1:0]       sum;
	logic [EXTW-1:0]       sum_ext;

	assign en      = !vld_o_q || out_ready;
	assign q_ready = en;

	assign vld_s[0] = q_valid;
	assign rem_s[0] = RW'(q_num);
	assign quo_s[0] = '0;
	assign den_s[0] = q_den;
	assign ctl_s[0] = q_ctrl;
	assign v_s[0]   = q_v;
	assign d_s[0]   = q_d;

	// One quotient bit per stage.
	for (genvar k = 1; k <= TF; k++) begin : g_div
		logic [RW-1:0] sh;
		logic [RW:0]   diff;

		assign sh   = {rem_s[k-1][RW-2:0], 1'b0};
		assign diff = (RW+1)'(sh) - (RW+1)'(den_s[k-1]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!diff[RW]) begin
					rem_s[k] <= diff[RW-1:0];
					quo_s[k] <= {quo_s[k-1][TF-2:0], 1'b1};
				end else begin
					rem_s[k] <= sh;
					quo_s[k] <= {quo_s[k-1][TF-2:0], 1'b0};
				end
				den_s[k] <= den_s[k-1];
				ctl_s[k] <= ctl_s[k-1];
				v_s[k]   <= v_s[k-1];
				d_s[k]   <= d_s[k-1];
			end
		end
	end

	always_comb begin
		case (ctl_s[TF].kind)
			T_ZERO:  t = '0;
			T_ONE:   t = TW'(1) << TF;
			default: t = {1'b0, quo_s[TF]};
		endcase
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			w[i] = (WW'(d_m1[i]) <<< TF) + WW'(tv_m1[i]);
		end
		sum = SUMW'(sq_m4[0]) + SUMW'(sq_m4[1]) + SUMW'(sq_m4[2]);
		sum_ext = EXTW'(sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_m1  <= 1'b0;
			vld_m2  <= 1'b0;
			vld_m3  <= 1'b0;
			vld_m4  <= 1'b0;
			vld_o_q <= 1'b0;
		end else if (en) begin
			vld_m1  <= vld_s[TF];
			vld_m2  <= vld_m1;
			vld_m3  <= vld_m2;
			vld_m4  <= vld_m3;
			vld_o_q <= vld_m4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				tv_m1[i] <= $signed({1'b0, t}) * $signed(v_s[TF][i*VW +: VW]);
				d_m1[i]  <= $signed(d_s[TF][i*VW +: VW]);
				mag_m2[i] <= w[i][WW-1] ? MW'(-w[i]) : MW'(w[i]);
				hh_m3[i] <= mag_m2[i][MW-1:LW] * mag_m2[i][MW-1:LW];
				hl_m3[i] <= mag_m2[i][MW-1:LW] * mag_m2[i][LW-1:0];
				ll_m3[i] <= mag_m2[i][LW-1:0] * mag_m2[i][LW-1:0];
				sq_m4[i] <= (SQW'(hh_m3[i]) << (2 * LW)) + (SQW'(hl_m3[i]) << (LW + 1))
					+ SQW'(ll_m3[i]);
			end
			degen_m1 <= ctl_s[TF].degen;
			degen_m2 <= degen_m1;
			degen_m3 <= degen_m2;
			degen_m4 <= degen_m3;
			degen_q  <= degen_m4;
			dist_q   <= sum_ext[2*TF +: DIST_BITS];
		end
	end

	assign out_valid    = vld_o_q;
	assign dist_squared = dist_q;
	assign degenerate   = degen_q;

endmodule

// ===== rtl/point_segment_distance_sq_3d_unit.sv =====
// Top level of the 3D point to segment squared distance unit.
// Each transaction on the input channel carries a segment start, a segment end and a query
// point as signed COORD_BITS-bit coordinates; each produces exactly one result transaction
// with the squared distance to the nearest point of the segment, truncated to an integer,
// and a flag that marks a zero-length segment (distance then taken to the start). The
// block accepts one transaction every cycle and delivers one every cycle when the output
// side is ready; each transaction passes through the four front stages, the queue, one
// restoring divider stage per fraction bit of t and five multiply, square and sum stages.
// Results come back in input order.
module point_segment_distance_sq_3d_unit
	import psd_pkg::*;
#(
	parameter int COORD_BITS  = 16,
	parameter int T_FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] seg_start_x,
	input  logic signed [COORD_BITS-1:0] seg_start_y,
	input  logic signed [COORD_BITS-1:0] seg_start_z,
	input  logic signed [COORD_BITS-1:0] seg_end_x,
	input  logic signed [COORD_BITS-1:0] seg_end_y,
	input  logic signed [COORD_BITS-1:0] seg_end_z,
	input  logic signed [COORD_BITS-1:0] query_x,
	input  logic signed [COORD_BITS-1:0] query_y,
	input  logic signed [COORD_BITS-1:0] query_z,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [DIST_BITS-1:0]         dist_squared,
	output logic                         degenerate
);

	localparam int VW = COORD_BITS + 1;
	localparam int AW = 2 * VW;
	localparam int CW = $bits(item_ctrl_t);
	localparam int QW = CW + 2 * AW + 6 * VW;

	// Front to queue.
	logic            f_valid;
	logic            f_ready;
	logic [3*VW-1:0] f_v;
	logic [3*VW-1:0] f_d;
	logic [AW-1:0]   f_num;
	logic [AW-1:0]   f_den;
	item_ctrl_t      f_ctrl;

	// Queue to back.
	logic            b_valid;
	logic            b_ready;
	logic [QW-1:0]   push_data;
	logic [QW-1:0]   pop_data;

	// The front end computes v = end - start and d = start - query, the two dot products,
	// and decides whether t is zero, one or needs the divider.
	psd_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.seg_start_x (seg_start_x),
		.seg_start_y (seg_start_y),
		.seg_start_z (seg_start_z),
		.seg_end_x   (seg_end_x),
		.seg_end_y   (seg_end_y),
		.seg_end_z   (seg_end_z),
		.query_x     (query_x),
		.query_y     (query_y),
		.query_z     (query_z),
		.q_valid     (f_valid),
		.q_ready     (f_ready),
		.q_v         (f_v),
		.q_d         (f_d),
		.q_num       (f_num),
		.q_den       (f_den),
		.q_ctrl      (f_ctrl)
	);

	assign push_data = {f_ctrl, f_num, f_den, f_v, f_d};

	// The queue lets the front end keep accepting while the back end is held by the output.
	psd_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (push_data),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (pop_data)
	);

	// The back end finishes t and forms the squared distance.
	psd_back #(
		.COORD_BITS  (COORD_BITS),
		.T_FRAC_BITS (T_FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (b_valid),
		.q_ready      (b_ready),
		.q_v          (pop_data[3*VW +: 3*VW]),
		.q_d          (pop_data[0 +: 3*VW]),
		.q_num        (pop_data[6*VW + AW +: AW]),
		.q_den        (pop_data[6*VW +: AW]),
		.q_ctrl       (item_ctrl_t'(pop_data[QW-1 -: CW])),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.dist_squared (dist_squared),
		.degenerate   (degenerate)
	);

endmodule

// ===== rtl/psd_checker.sv =====
// Port-level checker for the point to segment distance unit, bound to its top level.
module psd_checker
	import psd_pkg::*;
#(
	parameter int T_FRAC_BITS = 16
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [DIST_BITS-1:0] dist_squared,
	input logic                 degenerate
);

	// Front stages, queue, divider stages and the five closing stages.
	localparam int CAPACITY = 4 + QUEUE_DEPTH + T_FRAC_BITS + 5;

	logic [7:0] cnt_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_acc && !out_acc) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(dist_squared) && $stable(degenerate))
		else $error("result changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != 8'd0)
		else $error("result shown with no transaction in flight");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 8'(CAPACITY))
		else $error("more transactions in flight than the pipeline holds");

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 8'd0 |-> in_ready)
		else $error("empty unit refuses input");

endmodule

bind point_segment_distance_sq_3d_unit psd_checker #(
	.T_FRAC_BITS (T_FRAC_BITS)
) u_psd_checker (.*);

// ===== dv/tb.sv =====
// Self-checking testbench for the 3D point to segment squared distance unit.
`timescale 1ns / 100ps

module tb;
	import psd_pkg::*;

	localparam int CB = 16;
	localparam int TF = 16;
	localparam int LATENCY = TF + 10;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct {
		logic signed [CB-1:0] sx, sy, sz, ex, ey, ez, qx, qy, qz;
	} seg_query_t;

	typedef struct {
		logic [DIST_BITS-1:0] dist_sq;
		logic                 degen;
	} dist_result_t;

	logic clk;
	logic arst_n;
	logic in_valid, in_ready, out_valid, out_ready, degenerate;
	logic signed [CB-1:0] seg_start_x, seg_start_y, seg_start_z;
	logic signed [CB-1:0] seg_end_x, seg_end_y, seg_end_z;
	logic signed [CB-1:0] query_x, query_y, query_z;
	logic [DIST_BITS-1:0] dist_squared;

	seg_query_t   pending_queries[$];
	dist_result_t expected_dists[$];
	int errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_degen = 0;
	int idle_cycles = 0;
	bit no_idle = 0;
	bit hold_sender = 0;

	point_segment_distance_sq_3d_unit #(.COORD_BITS(CB), .T_FRAC_BITS(TF)) dut (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Squared distance predictor. Dot products fit easily in 64 bits; the offsets
	// carry TF fraction bits, so their squares need 128-bit arithmetic.
	function automatic dist_result_t predict_dist(seg_query_t q);
		dist_result_t r;
		longint v[3], d[3];
		longint a, b, num, t, w;
		logic [127:0] acc, m;
		longint rem;
		v[0] = longint'(q.ex) - q.sx;
		v[1] = longint'(q.ey) - q.sy;
		v[2] = longint'(q.ez) - q.sz;
		d[0] = longint'(q.sx) - q.qx;
		d[1] = longint'(q.sy) - q.qy;
		d[2] = longint'(q.sz) - q.qz;
		a = 0;
		b = 0;
		for (int i = 0; i < 3; i++) begin
			a += v[i] * v[i];
			b += v[i] * d[i];
		end
		num = -b;
		if (a == 0 || num <= 0) begin
			t = 0;
		end else if (num >= a) begin
			t = longint'(1) << TF;
		end else begin
			// Fraction of t, rounded down, by restoring division.
			rem = num;
			t = 0;
			for (int i = 0; i < TF; i++) begin
				rem = rem << 1;
				t = t << 1;
				if (rem >= a) begin
					rem -= a;
					t |= 1;
				end
			end
		end
		acc = 0;
		for (int i = 0; i < 3; i++) begin
			w = d[i] * (longint'(1) << TF) + t * v[i];
			m = (w < 0) ? 128'(-w) : 128'(w);
			acc += m * m;
		end
		r.dist_sq = DIST_BITS'(acc >> (2 * TF));
		r.degen = (a == 0);
		return r;
	endfunction

	function automatic logic signed [CB-1:0] rand_coord(int mode);
		case (mode)
			0: return CB'($urandom);
			1: return CB'(int'($urandom_range(0, 15)) - 8);
			2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			default: return CB'(int'($urandom_range(0, 400)) - 200);
		endcase
	endfunction

	task automatic add_query(seg_query_t q);
		pending_queries.push_back(q);
	endtask

	function automatic seg_query_t make_query(int mode);
		seg_query_t q;
		q.sx = rand_coord(mode); q.sy = rand_coord(mode); q.sz = rand_coord(mode);
		q.ex = rand_coord(mode); q.ey = rand_coord(mode); q.ez = rand_coord(mode);
		q.qx = rand_coord(mode); q.qy = rand_coord(mode); q.qz = rand_coord(mode);
		return q;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("mismatch on %s at result %0d: got %0d, expected %0d",
			what, n_checked, got, want);
	endtask

	// Driver: presents queued transactions, with random gaps between them.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			{seg_start_x, seg_start_y, seg_start_z} <= '0;
			{seg_end_x, seg_end_y, seg_end_z} <= '0;
			{query_x, query_y, query_z} <= '0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) begin
				n_sent++;
			end
			if (pending_queries.size() > 0 && !hold_sender &&
					(no_idle || $urandom_range(0, 99) >= 30)) begin
				seg_query_t q;
				q = pending_queries.pop_front();
				expected_dists.push_back(predict_dist(q));
				in_valid <= 1;
				seg_start_x <= q.sx; seg_start_y <= q.sy; seg_start_z <= q.sz;
				seg_end_x <= q.ex; seg_end_y <= q.ey; seg_end_z <= q.ez;
				query_x <= q.qx; query_y <= q.qy; query_z <= q.qz;
			end else begin
				in_valid <= 0;
			end
		end
	end

	// Monitor: checks each result against the oldest expectation and stalls the output.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_dists.size() == 0) begin
					report_mismatch("unexpected result", 1, 0);
				end else begin
					dist_result_t e;
					e = expected_dists.pop_front();
					if (dist_squared !== e.dist_sq)
						report_mismatch("dist_squared", dist_squared, e.dist_sq);
					if (degenerate !== e.degen)
						report_mismatch("degenerate", degenerate, e.degen);
					if (e.degen)
						n_degen++;
				end
				n_checked++;
			end
			out_ready <= no_idle || $urandom_range(0, 99) >= 30;
		end
	end

	// Watchdog: counts cycles in which neither channel moves a transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired with %0d results outstanding",
					expected_dists.size());
				$display("tb failed");
				$finish;
			end
		end
	end

	initial begin
		seg_query_t q;
		arst_n = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;

		// Directed: degenerate segment, projection before the start, past the end,
		// in the interior, and the coordinate extremes.
		q = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
		add_query(q);
		q = '{5, -3, 7, 5, -3, 7, -2, 9, 1};
		add_query(q);
		q = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
			16'sh7fff, 16'sh7fff, 16'sh7fff};
		add_query(q);
		q = '{0, 0, 0, 10, 0, 0, -5, 3, 0};
		add_query(q);
		q = '{0, 0, 0, 10, 0, 0, 15, 3, 0};
		add_query(q);
		q = '{0, 0, 0, 10, 0, 0, 10, 3, 4};
		add_query(q);
		q = '{0, 0, 0, 3, 0, 0, 1, 1, 1};
		add_query(q);
		q = '{0, 0, 0, 7, 5, 3, 2, 9, -4};
		add_query(q);
		q = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff,
			16'sh7fff, 16'sh8000, 16'sh7fff};
		add_query(q);
		q = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff,
			0, 0, 0};
		add_query(q);
		q = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
			16'sh8000, 16'sh7fff, 16'sh8000};
		add_query(q);
		q = '{-1, -1, -1, 16'sh7fff, 16'sh7fff, 16'sh7fff, 100, -100, 16'sh8000};
		add_query(q);
		for (int i = 0; i < 8; i++)
			add_query(make_query(2));

		// Let the whole pipeline drain before the random part.
		wait (pending_queries.size() == 0);
		hold_sender = 1;
		wait (expected_dists.size() == 0 && !in_valid);
		hold_sender = 0;

		for (int i = 0; i < 1530; i++) begin
			q = make_query($urandom_range(0, 3));
			if ($urandom_range(0, 9) == 0) begin
				q.ex = q.sx; q.ey = q.sy; q.ez = q.sz;
			end
			add_query(q);
			if (i == 600)
				no_idle = 1;
			if (i == 900)
				no_idle = 0;
			// Keep the queue short so the no-idle stretch lands where intended.
			wait (pending_queries.size() < 4);
		end

		wait (pending_queries.size() == 0 && !in_valid && expected_dists.size() == 0);
		repeat (LATENCY * 2) @(posedge clk);

		$display("%0d transactions sent, %0d results checked, %0d degenerate segments",
			n_sent, n_checked, n_degen);
		if (errors == 0 && expected_dists.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

// ===== point_segment_distance_sq_3d_unit.f =====
rtl/psd_pkg.sv
rtl/psd_front.sv
rtl/psd_queue.sv
rtl/psd_back.sv
rtl/point_segment_distance_sq_3d_unit.sv
rtl/psd_checker.sv
dv/tb.sv
